// ===== rtl/core/serial_shift_register_pwm_assert.svh =====
// Assertion macros for the serial shift register PWM block.
// Uses the clk and rst_n names of the module that includes it.
`ifndef SERIAL_SHIFT_REGISTER_PWM_ASSERT_SVH
`define SERIAL_SHIFT_REGISTER_PWM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSRP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SSRP_ASSERT(label, prop, msg)
`define SSRP_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/core/ssrp_pkg.sv =====
// Shared types and constants for the serial shift register PWM block.
// No dependencies; used by ssrp_front, ssrp_back and the top level.
package ssrp_pkg;

  localparam int ADDR_W      = 10;
  localparam int TABLE_DEPTH = 1024;
  localparam int CHAN_W      = 10;
  localparam int DUTY_W      = 9;
  localparam int MODE_W      = 2;
  localparam int OUT_W       = 18;
  localparam int STEP_OUT_W  = 8;
  localparam int POS_OUT_W   = 6;

  // configuration register widths and the largest values they can hold
  localparam int NPOS_W     = 7;
  localparam int NCH_W      = 5;
  localparam int NPOS_MAX   = 127;
  localparam int NCH_MAX    = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAINS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_EN   = 2'd2;

  localparam logic [NPOS_W-1:0] POSITIONS_RST = 7'd8;
  localparam logic [NCH_W-1:0]  CHAINS_RST    = 5'd1;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_COMMIT,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAN_W-1:0] chan;
    logic [DUTY_W-1:0] duty;
  } q_entry_t;

  // clamped configuration as the back end sees it
  typedef struct packed {
    logic [NPOS_W-1:0] npos;
    logic [NCH_W-1:0]  nch;
    logic              test_en;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_COPY,
    BK_RD,
    BK_DRAIN,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== rtl/core/ssrp_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
// Depends on ssrp_pkg.
module ssrp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ssrp_pkg::MODE_W-1:0]    in_mode,
  input  logic [ssrp_pkg::CHAN_W-1:0]    in_channel_index,
  input  logic [ssrp_pkg::DUTY_W-1:0]    in_duty,
  input  logic                           clearing,
  output logic                           q_valid,
  output ssrp_pkg::q_entry_t             q_entry,
  input  logic                           q_pop
);

  localparam int Q_DEPTH = ssrp_pkg::Q_DEPTH;
  localparam int Q_AW    = ssrp_pkg::Q_AW;

  ssrp_pkg::q_entry_t q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]      count_r, count_nxt;

  logic               accept;
  logic               push;
  ssrp_pkg::q_entry_t entry;

  assign in_ready = (count_r != Q_AW'(0) + (Q_AW+1)'(Q_DEPTH)) && !clearing;
  assign accept   = in_valid && in_ready;

  // mode three is taken and dropped
  always_comb begin
    entry.chan = in_channel_index;
    entry.duty = in_duty;
    entry.op   = ssrp_pkg::OP_WRITE;
    push       = 1'b0;
    unique case (in_mode)
      ssrp_pkg::MODE_WRITE: begin
        entry.op = ssrp_pkg::OP_WRITE;
        push     = accept;
      end
      ssrp_pkg::MODE_COMMIT: begin
        entry.op = ssrp_pkg::OP_COMMIT;
        push     = accept;
      end
      ssrp_pkg::MODE_TICK: begin
        entry.op = ssrp_pkg::OP_TICK;
        push     = accept;
      end
      default: push = 1'b0;
    endcase
  end

  assign q_valid = (count_r != '0);
  assign q_entry = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== rtl/core/ssrp_back.sv =====
// Back end: duty tables, commit copy, reset clearing pass and word building.
// Depends on ssrp_pkg; fed from ssrp_front's queue.
module ssrp_back #(
  parameter int RESOLUTION    = 256,
  parameter int MAX_CHAINS    = 16,
  parameter int MAX_POSITIONS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssrp_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  input  ssrp_pkg::q_entry_t                q_entry,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ssrp_pkg::OUT_W-1:0]        out_word,
  output logic [ssrp_pkg::STEP_OUT_W-1:0]   out_step_index,
  output logic [ssrp_pkg::POS_OUT_W-1:0]    out_position_index
);

  localparam int ADDR_W   = ssrp_pkg::ADDR_W;
  localparam int DEPTH    = ssrp_pkg::TABLE_DEPTH;
  localparam int DUTY_W   = ssrp_pkg::DUTY_W;
  localparam int OUT_W    = ssrp_pkg::OUT_W;
  localparam int NPOS_W   = ssrp_pkg::NPOS_W;
  localparam int NCH_W    = ssrp_pkg::NCH_W;
  localparam int SH_W     = NCH_W + 1;
  localparam int STEP_W   = $clog2(RESOLUTION);
  localparam int POS_LIM  = (MAX_POSITIONS < ssrp_pkg::NPOS_MAX) ?
                            MAX_POSITIONS : ssrp_pkg::NPOS_MAX;
  localparam int POS_W    = (POS_LIM > 1) ? $clog2(POS_LIM) : 1;
  localparam int CH_LIM   = (MAX_CHAINS < ssrp_pkg::NCH_MAX) ?
                            MAX_CHAINS : ssrp_pkg::NCH_MAX;
  localparam int K_W      = (CH_LIM > 1) ? $clog2(CH_LIM) : 1;
  localparam int ACC_RAW  = $clog2(CH_LIM * POS_LIM + 1);
  localparam int ACC_W    = (ACC_RAW > ADDR_W) ? ACC_RAW : ADDR_W + 1;
  localparam int CMP_W    = (STEP_W > DUTY_W) ? STEP_W : DUTY_W;
  localparam int SX_W     = (STEP_W > ssrp_pkg::STEP_OUT_W) ? STEP_W : ssrp_pkg::STEP_OUT_W;
  localparam int PX_W     = (POS_W > ssrp_pkg::POS_OUT_W) ? POS_W : ssrp_pkg::POS_OUT_W;

  ssrp_pkg::bk_state_t state_r, state_nxt;

  logic [ADDR_W:0]       sweep_r, sweep_nxt;
  logic                  commit_r, commit_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [K_W-1:0]        rd_k_r, rd_k_nxt;
  logic [OUT_W-1:0]      word_r, word_nxt;
  logic                  cp_pend_r, cp_pend_nxt;
  logic [ADDR_W-1:0]     cp_addr_r, cp_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_word_r, out_word_nxt;
  logic [ssrp_pkg::STEP_OUT_W-1:0] out_step_r, out_step_nxt;
  logic [ssrp_pkg::POS_OUT_W-1:0]  out_pos_r, out_pos_nxt;

  logic [DUTY_W-1:0]     pend_mem [DEPTH];
  logic [DUTY_W-1:0]     shown_mem [DEPTH];
  logic [DUTY_W-1:0]     pend_q_r;
  logic [DUTY_W-1:0]     shown_q_r;

  logic                  pend_we;
  logic [ADDR_W-1:0]     pend_waddr;
  logic [DUTY_W-1:0]     pend_wdata;
  logic                  shown_we;
  logic [ADDR_W-1:0]     shown_waddr;
  logic [DUTY_W-1:0]     shown_wdata;

  logic [POS_W-1:0]      pos_eff;
  logic                  k_last;
  logic                  acc_in_range;
  logic                  hit;
  logic [OUT_W-1:0]      word_upd;
  logic                  out_free;
  logic [OUT_W-1:0]      latch_mask;
  logic [OUT_W-1:0]      test_mask;
  logic [SX_W-1:0]       step_x;
  logic [PX_W-1:0]       pos_x;
  logic                  pos_wrap;
  logic                  frame_copy;

  // a shrunk positions register can leave the counter out of range
  assign pos_eff      = (NPOS_W'(pos_r) >= cfg.npos) ? '0 : pos_r;
  assign frame_copy   = (pos_eff == '0) && (step_r == '0) && commit_r;
  assign k_last       = (NCH_W'(k_r) == cfg.nch - NCH_W'(1));
  assign acc_in_range = (acc_r[ACC_W-1:ADDR_W] == '0);
  assign hit          = rd_pend_r && (CMP_W'(step_r) < CMP_W'(shown_q_r));
  // chains at or beyond the word width shift out and vanish
  assign word_upd     = word_r | (hit ? (OUT_W'(1) << rd_k_r) : '0);
  assign out_free     = !out_valid_r || out_ready;
  assign latch_mask   = (pos_r == '0) ? (OUT_W'(1) << cfg.nch) : '0;
  assign test_mask    = (cfg.test_en && step_r == '0) ?
                        (OUT_W'(1) << (SH_W'(cfg.nch) + SH_W'(1))) : '0;
  assign step_x       = SX_W'(step_r);
  assign pos_x        = PX_W'(pos_r);
  assign pos_wrap     = (NPOS_W'(pos_r) + NPOS_W'(1) >= cfg.npos);

  assign clearing           = (state_r == ssrp_pkg::BK_CLEAR);
  assign q_pop              = (state_r == ssrp_pkg::BK_IDLE) && q_valid;
  assign out_valid          = out_valid_r;
  assign out_word           = out_word_r;
  assign out_step_index     = out_step_r;
  assign out_position_index = out_pos_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssrp_pkg::BK_CLEAR: begin
        if (sweep_r[ADDR_W-1:0] == '1) state_nxt = ssrp_pkg::BK_IDLE;
      end
      ssrp_pkg::BK_IDLE: begin
        if (q_valid && q_entry.op == ssrp_pkg::OP_TICK) begin
          state_nxt = frame_copy ? ssrp_pkg::BK_COPY : ssrp_pkg::BK_RD;
        end
      end
      ssrp_pkg::BK_COPY: begin
        if (sweep_r[ADDR_W]) state_nxt = ssrp_pkg::BK_RD;
      end
      ssrp_pkg::BK_RD: begin
        if (k_last) state_nxt = ssrp_pkg::BK_DRAIN;
      end
      ssrp_pkg::BK_DRAIN: state_nxt = ssrp_pkg::BK_EMIT;
      ssrp_pkg::BK_EMIT: begin
        if (out_free) state_nxt = ssrp_pkg::BK_IDLE;
      end
      default: state_nxt = ssrp_pkg::BK_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    sweep_nxt     = sweep_r;
    commit_nxt    = commit_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    rd_pend_nxt   = 1'b0;
    rd_k_nxt      = rd_k_r;
    word_nxt      = word_r;
    cp_pend_nxt   = 1'b0;
    cp_addr_nxt   = cp_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_step_nxt  = out_step_r;
    out_pos_nxt   = out_pos_r;

    pend_we     = 1'b0;
    pend_waddr  = sweep_r[ADDR_W-1:0];
    pend_wdata  = '0;
    shown_we    = 1'b0;
    shown_waddr = sweep_r[ADDR_W-1:0];
    shown_wdata = '0;

    if (cp_pend_r) begin
      shown_we    = 1'b1;
      shown_waddr = cp_addr_r;
      shown_wdata = pend_q_r;
    end

    unique case (state_r)
      ssrp_pkg::BK_CLEAR: begin
        sweep_nxt = sweep_r + 1'b1;
        pend_we   = 1'b1;
        shown_we  = 1'b1;
      end
      ssrp_pkg::BK_IDLE: begin
        if (q_valid) begin
          unique case (q_entry.op)
            ssrp_pkg::OP_WRITE: begin
              pend_we    = 1'b1;
              pend_waddr = q_entry.chan;
              pend_wdata = q_entry.duty;
            end
            ssrp_pkg::OP_COMMIT: commit_nxt = 1'b1;
            ssrp_pkg::OP_TICK: begin
              pos_nxt   = pos_eff;
              k_nxt     = '0;
              acc_nxt   = ACC_W'(pos_eff);
              word_nxt  = '0;
              sweep_nxt = '0;
            end
            default: commit_nxt = commit_r;
          endcase
        end
      end
      ssrp_pkg::BK_COPY: begin
        // read pending, then write the registered value to shown in the next cycle
        if (!sweep_r[ADDR_W]) begin
          sweep_nxt   = sweep_r + 1'b1;
          cp_pend_nxt = 1'b1;
          cp_addr_nxt = sweep_r[ADDR_W-1:0];
        end else begin
          commit_nxt = 1'b0;
        end
      end
      ssrp_pkg::BK_RD: begin
        rd_pend_nxt = acc_in_range;
        rd_k_nxt    = k_r;
        k_nxt       = k_r + 1'b1;
        acc_nxt     = acc_r + ACC_W'(cfg.npos);
        word_nxt    = word_upd;
      end
      ssrp_pkg::BK_DRAIN: word_nxt = word_upd;
      ssrp_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = word_r | latch_mask | test_mask;
          out_step_nxt  = step_x[ssrp_pkg::STEP_OUT_W-1:0];
          out_pos_nxt   = pos_x[ssrp_pkg::POS_OUT_W-1:0];
          if (pos_wrap) begin
            pos_nxt  = '0;
            step_nxt = (step_r == STEP_W'(RESOLUTION - 1)) ? '0 : step_r + 1'b1;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: sweep_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssrp_pkg::BK_CLEAR;
      sweep_r     <= '0;
      commit_r    <= 1'b0;
      pos_r       <= '0;
      step_r      <= '0;
      rd_pend_r   <= 1'b0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      commit_r    <= commit_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      rd_pend_r   <= rd_pend_nxt;
      cp_pend_r   <= cp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    rd_k_r     <= rd_k_nxt;
    word_r     <= word_nxt;
    cp_addr_r  <= cp_addr_nxt;
    out_word_r <= out_word_nxt;
    out_step_r <= out_step_nxt;
    out_pos_r  <= out_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    pend_q_r <= pend_mem[sweep_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (shown_we) begin
      shown_mem[shown_waddr] <= shown_wdata;
    end
    shown_q_r <= shown_mem[acc_r[ADDR_W-1:0]];
  end

endmodule

// ===== rtl/core/serial_shift_register_pwm.sv =====
// PWM driver for parallel chains of serial shift registers: top level.
// Holds the configuration registers; depends on ssrp_pkg, ssrp_front, ssrp_back.
//
// After reset the block clears both duty tables, all 1024 entries, and takes
// no transaction meanwhile (configuration writes are still taken). A duty write
// or a commit is done in the back end's idle state; mode three is taken and dropped.
// A tick reads the shown table through its one read port and builds the word
// one chain per cycle. A tick that opens a frame with a commit waiting first
// copies the pending table into the shown table. A four-entry queue sits
// between the input and the table logic, and the result register lets the next
// transaction in while a word waits.
`include "serial_shift_register_pwm_assert.svh"

module serial_shift_register_pwm #(
  parameter int RESOLUTION    = 256,
  parameter int MAX_CHAINS    = 16,
  parameter int MAX_POSITIONS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ssrp_pkg::MODE_W-1:0]        in_mode,
  input  logic [ssrp_pkg::CHAN_W-1:0]        in_channel_index,
  input  logic [ssrp_pkg::DUTY_W-1:0]        in_duty,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ssrp_pkg::OUT_W-1:0]         out_word,
  output logic [ssrp_pkg::STEP_OUT_W-1:0]    out_step_index,
  output logic [ssrp_pkg::POS_OUT_W-1:0]     out_position_index,
  input  logic                               cfg_write_en,
  input  logic [ssrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssrp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NPOS_W = ssrp_pkg::NPOS_W;
  localparam int NCH_W  = ssrp_pkg::NCH_W;

  logic [NPOS_W-1:0]  positions_r, positions_nxt;
  logic [NCH_W-1:0]   chains_r, chains_nxt;
  logic               test_en_r, test_en_nxt;

  ssrp_pkg::cfg_t     cfg;
  logic               q_valid;
  ssrp_pkg::q_entry_t q_entry;
  logic               q_pop;
  logic               clearing;

  always_comb begin
    positions_nxt = positions_r;
    chains_nxt    = chains_r;
    test_en_nxt   = test_en_r;
    if (cfg_write_en) begin
      unique case (cfg_index)
        ssrp_pkg::CFG_POSITIONS: positions_nxt = cfg_wdata[NPOS_W-1:0];
        ssrp_pkg::CFG_CHAINS:    chains_nxt    = cfg_wdata[NCH_W-1:0];
        ssrp_pkg::CFG_TEST_EN:   test_en_nxt   = cfg_wdata[0];
        default:                 test_en_nxt   = test_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      positions_r <= ssrp_pkg::POSITIONS_RST;
      chains_r    <= ssrp_pkg::CHAINS_RST;
      test_en_r   <= 1'b0;
    end else begin
      positions_r <= positions_nxt;
      chains_r    <= chains_nxt;
      test_en_r   <= test_en_nxt;
    end
  end

  // zero reads as one, anything above the build limit as the limit
  always_comb begin
    priority if (positions_r == '0) begin
      cfg.npos = NPOS_W'(1);
    end else if (int'(positions_r) > MAX_POSITIONS) begin
      cfg.npos = NPOS_W'(MAX_POSITIONS);
    end else begin
      cfg.npos = positions_r;
    end
    priority if (chains_r == '0) begin
      cfg.nch = NCH_W'(1);
    end else if (int'(chains_r) > MAX_CHAINS) begin
      cfg.nch = NCH_W'(MAX_CHAINS);
    end else begin
      cfg.nch = chains_r;
    end
    cfg.test_en = test_en_r;
  end

  ssrp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_channel_index (in_channel_index),
    .in_duty          (in_duty),
    .clearing         (clearing),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop)
  );

  ssrp_back #(
    .RESOLUTION    (RESOLUTION),
    .MAX_CHAINS    (MAX_CHAINS),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_valid            (q_valid),
    .q_entry            (q_entry),
    .q_pop              (q_pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_word           (out_word),
    .out_step_index     (out_step_index),
    .out_position_index (out_position_index)
  );

  `SSRP_NEVER(a_no_accept_in_clear, in_valid && in_ready && clearing, "transaction taken during clear")
  `SSRP_ASSERT(a_pop_needs_entry, q_pop |-> q_valid, "queue popped while empty")
  `SSRP_NEVER(a_no_result_in_clear, clearing && out_valid, "result shown during clear")

endmodule

// ===== verif/ssrp_checker.sv =====
`timescale 1ns / 1ps
// Checker for serial_shift_register_pwm: watches the input, result and
// configuration ports, predicts each output word and compares it.
// Depends on ssrp_pkg for field widths, mode codes and register indexes.
module ssrp_checker
  import ssrp_pkg::*;
#(
  parameter int RESOLUTION    = 256,
  parameter int MAX_CHAINS    = 16,
  parameter int MAX_POSITIONS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [CHAN_W-1:0]     in_channel_index,
  input  logic [DUTY_W-1:0]     in_duty,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [OUT_W-1:0]      out_word,
  input  logic [STEP_OUT_W-1:0] out_step_index,
  input  logic [POS_OUT_W-1:0]  out_position_index,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  run_done,
  output int                    fail_count,
  output int                    words_waiting,
  output int                    words_checked,
  output int                    table_copies
);

  typedef struct packed {
    logic [OUT_W-1:0]      word;
    logic [STEP_OUT_W-1:0] step;
    logic [POS_OUT_W-1:0]  pos;
  } pwm_word_t;

  logic [DUTY_W-1:0] pend_duty  [TABLE_DEPTH];
  logic [DUTY_W-1:0] shown_duty [TABLE_DEPTH];
  logic              commit_armed;
  int                pos_ctr;
  int                step_ctr;
  logic [NPOS_W-1:0] cfg_npos;
  logic [NCH_W-1:0]  cfg_nch;
  logic              cfg_marker;

  pwm_word_t expected_words[$];
  int        fails;
  int        words_seen;
  int        copies;
  bit        closed;

  initial begin
    fails      = 0;
    words_seen = 0;
    copies     = 0;
    closed     = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fails++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Builds the word for the current position and step, then moves the counters on.
  function automatic pwm_word_t advance_tick();
    pwm_word_t w;
    int        npos;
    int        nch;
    int        chan;
    w    = '0;
    npos = (cfg_npos == 0) ? 1 : (cfg_npos > MAX_POSITIONS) ? MAX_POSITIONS : int'(cfg_npos);
    nch  = (cfg_nch == 0) ? 1 : (cfg_nch > MAX_CHAINS) ? MAX_CHAINS : int'(cfg_nch);
    if (pos_ctr >= npos) pos_ctr = 0;
    if (step_ctr >= RESOLUTION) step_ctr = 0;
    // frame start: a waiting commit lands before the word is built
    if (pos_ctr == 0 && step_ctr == 0 && commit_armed) begin
      for (int i = 0; i < TABLE_DEPTH; i++) shown_duty[i] = pend_duty[i];
      commit_armed = 1'b0;
      copies++;
    end
    for (int k = 0; k < nch; k++) begin
      chan = k * npos + pos_ctr;
      if (chan < TABLE_DEPTH && step_ctr < int'(shown_duty[chan])) w.word[k] = 1'b1;
    end
    if (pos_ctr == 0) w.word[nch] = 1'b1;
    if (cfg_marker && step_ctr == 0) w.word[nch + 1] = 1'b1;
    w.step = step_ctr[STEP_OUT_W-1:0];
    w.pos  = pos_ctr[POS_OUT_W-1:0];
    pos_ctr++;
    if (pos_ctr >= npos) begin
      pos_ctr = 0;
      step_ctr++;
      if (step_ctr >= RESOLUTION) step_ctr = 0;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    pwm_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        pend_duty[i]  = '0;
        shown_duty[i] = '0;
      end
      commit_armed = 1'b0;
      pos_ctr      = 0;
      step_ctr     = 0;
      cfg_npos     = POSITIONS_RST;
      cfg_nch      = CHAINS_RST;
      cfg_marker   = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_POSITIONS: cfg_npos   = cfg_wdata[NPOS_W-1:0];
          CFG_CHAINS:    cfg_nch    = cfg_wdata[NCH_W-1:0];
          CFG_TEST_EN:   cfg_marker = cfg_wdata[0];
          default: ;
        endcase
      end

      // outputs first: a word leaving now was produced by an earlier transaction
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %h step %0d pos %0d with nothing expected",
                                    out_word, out_step_index, out_position_index));
        end else begin
          want = expected_words.pop_front();
          words_seen++;
          if (out_word !== want.word)
            report_mismatch($sformatf("out_word %h, expected %h (step %0d pos %0d)",
                                      out_word, want.word, want.step, want.pos));
          if (out_step_index !== want.step)
            report_mismatch($sformatf("out_step_index %0d, expected %0d",
                                      out_step_index, want.step));
          if (out_position_index !== want.pos)
            report_mismatch($sformatf("out_position_index %0d, expected %0d",
                                      out_position_index, want.pos));
        end
      end

      if (in_valid && in_ready) begin
        case (in_mode)
          MODE_WRITE:  pend_duty[in_channel_index] = in_duty;
          MODE_COMMIT: commit_armed = 1'b1;
          MODE_TICK:   expected_words.push_back(advance_tick());
          default: ;
        endcase
      end

      if (run_done && !closed) begin
        closed = 1'b1;
        if (expected_words.size() != 0)
          report_mismatch($sformatf("%0d expected words never arrived",
                                    expected_words.size()));
      end
    end
    fail_count    <= fails;
    words_waiting <= expected_words.size();
    words_checked <= words_seen;
    table_copies  <= copies;
  end

endmodule

// ===== verif/tb_serial_shift_register_pwm.sv =====
`timescale 1ns / 1ps
// Testbench top for serial_shift_register_pwm: clock, reset, stimulus and verdict.
// Depends on ssrp_pkg, the block itself and ssrp_checker for prediction.
module tb_serial_shift_register_pwm;
  import ssrp_pkg::*;

  localparam int RESOLUTION    = 256;
  localparam int MAX_CHAINS    = 16;
  localparam int MAX_POSITIONS = 64;
  localparam int PHASE_ITEMS   = 215;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 20000;

  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [MODE_W-1:0]     in_mode;
  logic [CHAN_W-1:0]     in_channel_index;
  logic [DUTY_W-1:0]     in_duty;
  logic                  out_valid;
  logic                  out_ready;
  logic [OUT_W-1:0]      out_word;
  logic [STEP_OUT_W-1:0] out_step_index;
  logic [POS_OUT_W-1:0]  out_position_index;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  run_done;

  int fail_count;
  int words_waiting;
  int words_checked;
  int table_copies;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int n_writes       = 0;
  int n_commits      = 0;
  int n_ticks        = 0;
  int n_ignored      = 0;
  int n_settings     = 0;
  int quiet_cycles   = 0;

  serial_shift_register_pwm #(
    .RESOLUTION    (RESOLUTION),
    .MAX_CHAINS    (MAX_CHAINS),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_channel_index   (in_channel_index),
    .in_duty            (in_duty),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_word           (out_word),
    .out_step_index     (out_step_index),
    .out_position_index (out_position_index),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  ssrp_checker #(
    .RESOLUTION    (RESOLUTION),
    .MAX_CHAINS    (MAX_CHAINS),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_channel_index   (in_channel_index),
    .in_duty            (in_duty),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_word           (out_word),
    .out_step_index     (out_step_index),
    .out_position_index (out_position_index),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .run_done           (run_done),
    .fail_count         (fail_count),
    .words_waiting      (words_waiting),
    .words_checked      (words_checked),
    .table_copies       (table_copies)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", quiet_cycles);
      $display("FAIL serial_shift_register_pwm");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                       input logic [DUTY_W-1:0] duty);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_channel_index <= chan;
    in_duty          <= duty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (mode)
      MODE_WRITE:  n_writes++;
      MODE_COMMIT: n_commits++;
      MODE_TICK:   n_ticks++;
      default:     n_ignored++;
    endcase
  endtask

  // wait until every expected word is out and queued writes have drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [NPOS_W-1:0] npos_data,
                               input logic [NCH_W-1:0] nch_data, input logic marker);
    logic [1:0] nch_pad;
    logic [5:0] marker_pad;
    nch_pad    = 2'($urandom_range(3));
    marker_pad = 6'($urandom_range(63));
    drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_POSITIONS;
    cfg_wdata    <= npos_data;
    @(posedge clk);
    cfg_index    <= CFG_CHAINS;
    cfg_wdata    <= {nch_pad, nch_data};
    @(posedge clk);
    cfg_index    <= CFG_TEST_EN;
    cfg_wdata    <= {marker_pad, marker};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input logic [NPOS_W-1:0] npos_data, input logic [NCH_W-1:0] nch_data,
                           input logic marker, input int send_pct, input int recv_pct,
                           input int tick_pct, input bit squeeze);
    int               sent;
    int               roll;
    int               npos_eff;
    int               nch_eff;
    logic [CHAN_W-1:0] chan;
    logic [DUTY_W-1:0] duty;
    set_registers(npos_data, nch_data, marker);
    npos_eff = (npos_data == 0) ? 1 :
               (int'(npos_data) > MAX_POSITIONS) ? MAX_POSITIONS : int'(npos_data);
    nch_eff  = (nch_data == 0) ? 1 :
               (int'(nch_data) > MAX_CHAINS) ? MAX_CHAINS : int'(nch_data);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    // receiver holds off while the sender keeps going, so the input backs up
    if (squeeze) hold_asks++;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      roll = int'($urandom_range(99));
      chan = CHAN_W'($urandom_range(TABLE_DEPTH - 1));
      duty = DUTY_W'($urandom_range(511));
      if (roll < tick_pct) begin
        offer(MODE_TICK, chan, duty);
        sent++;
      end else if (roll < tick_pct + 3) begin
        offer(MODE_SPARE, chan, duty);
      end else if (roll < tick_pct + 7) begin
        offer(MODE_COMMIT, chan, duty);
        sent++;
      end else begin
        // mostly channels that the current layout actually displays
        if ($urandom_range(4) != 0)
          chan = CHAN_W'($urandom_range(nch_eff - 1) * npos_eff +
                         $urandom_range(npos_eff - 1));
        case ($urandom_range(7))
          0: duty = 9'd0;
          1: duty = 9'd1;
          2: duty = 9'd255;
          3: duty = 9'd256;
          4: duty = 9'd511;
          5: duty = DUTY_W'($urandom_range(RESOLUTION));
          default: ;
        endcase
        offer(MODE_WRITE, chan, duty);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_mode          <= MODE_WRITE;
    in_channel_index <= '0;
    in_duty          <= '0;
    cfg_write_en     <= 1'b0;
    cfg_index        <= CFG_POSITIONS;
    cfg_wdata        <= '0;
    run_done         <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset layout: eight positions, one chain
    offer(MODE_SPARE, 10'h3FF, 9'h1FF);
    offer(MODE_WRITE, 10'd0, 9'd256);
    offer(MODE_WRITE, 10'd1, 9'd0);
    offer(MODE_WRITE, 10'd2, 9'd511);
    offer(MODE_WRITE, 10'd3, 9'd1);
    offer(MODE_WRITE, 10'd7, 9'd255);
    offer(MODE_WRITE, 10'h3FF, 9'h1FF);
    offer(MODE_COMMIT, 10'd0, 9'd0);
    offer(MODE_COMMIT, 10'h3FF, 9'h1FF);
    repeat (9) offer(MODE_TICK, 10'd0, 9'd0);
    offer(MODE_WRITE, 10'd1, 9'd300);
    offer(MODE_COMMIT, 10'd0, 9'd0);
    offer(MODE_TICK, 10'd0, 9'd0);

    // a write to the spare index must change nothing
    drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_SPARE;
    cfg_wdata    <= 7'h7F;
    @(posedge clk);
    cfg_write_en <= 1'b0;

    //        npos    nch    mark  send recv tick squeeze
    run_phase(7'd1,   5'd16, 1'b1, 0,   0,   85,  1'b0);
    run_phase(7'd127, 5'd31, 1'b0, 66,  0,   60,  1'b0);
    run_phase(7'd0,   5'd0,  1'b1, 0,   66,  85,  1'b0);
    run_phase(7'd3,   5'd5,  1'b1, 36,  36,  65,  1'b0);
    run_phase(7'd2,   5'd7,  1'b0, 0,   0,   65,  1'b1);
    run_phase(7'd65,  5'd17, 1'b1, 36,  36,  60,  1'b0);
    run_phase(7'd1,   5'd2,  1'b0, 66,  0,   85,  1'b0);
    run_phase(7'd64,  5'd16, 1'b1, 0,   66,  60,  1'b0);

    drain();
    run_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    $display("Sent %0d duty writes, %0d commits, %0d ticks, %0d ignored items over %0d layouts.",
             n_writes, n_commits, n_ticks, n_ignored, n_settings);
    $display("Compared %0d output words; pending table copied %0d times at frame start.",
             words_checked, table_copies);
    if (fail_count == 0) begin
      $display("PASS serial_shift_register_pwm");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL serial_shift_register_pwm");
    end
    $finish;
  end

endmodule

// ===== serial_shift_register_pwm.f =====
+incdir+rtl/core
rtl/core/ssrp_pkg.sv
rtl/core/ssrp_front.sv
rtl/core/ssrp_back.sv
rtl/core/serial_shift_register_pwm.sv
verif/ssrp_checker.sv
verif/tb_serial_shift_register_pwm.sv
